/* hw/rtl/akgd_pkg.sv */
package akgd_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// short queue between classifier and gesture logic
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SAMPLE_W-1:0] UP_BAND_LOW_RST     = SAMPLE_W'(300);
	localparam logic [SAMPLE_W-1:0] UP_BAND_HIGH_RST    = SAMPLE_W'(800);
	localparam logic [SAMPLE_W-1:0] ENTER_BAND_LOW_RST  = SAMPLE_W'(1600);
	localparam logic [SAMPLE_W-1:0] ENTER_BAND_HIGH_RST = SAMPLE_W'(3000);
	localparam logic [MS_W-1:0]     HOLD_TIME_RST       = MS_W'(5000);
	localparam logic [MS_W-1:0]     DOUBLE_WINDOW_RST   = MS_W'(500);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_BAND_LOW     = 3'd0,
		REG_UP_BAND_HIGH    = 3'd1,
		REG_ENTER_BAND_LOW  = 3'd2,
		REG_ENTER_BAND_HIGH = 3'd3,
		REG_HOLD_TIME       = 3'd4,
		REG_DOUBLE_WINDOW   = 3'd5
	} reg_index_t;

	typedef enum logic {
		EVENT_MUTE = 1'b0,
		EVENT_HOME = 1'b1
	} event_kind_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] up_band_low;
		logic [SAMPLE_W-1:0] up_band_high;
		logic [SAMPLE_W-1:0] enter_band_low;
		logic [SAMPLE_W-1:0] enter_band_high;
		logic [MS_W-1:0]     hold_time_ms;
		logic [MS_W-1:0]     double_window_ms;
	} cfg_t;

	// classified sample as it travels through the queue
	typedef struct packed {
		logic              is_up;
		logic              is_enter;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* hw/rtl/akgd_if.sv */
interface akgd_in_if;
	logic                          valid;
	logic                          ready;
	logic [akgd_pkg::SAMPLE_W-1:0] sample;
	logic [akgd_pkg::TIME_W-1:0]   now_ms;

	modport source(output valid, output sample, output now_ms, input ready);
	modport sink(input valid, input sample, input now_ms, output ready);
endinterface

interface akgd_out_if;
	logic valid;
	logic ready;
	logic event_kind;

	modport source(output valid, output event_kind, input ready);
	modport sink(input valid, input event_kind, output ready);
endinterface

interface akgd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [akgd_pkg::CFG_IDX_W-1:0]  index;
	logic [akgd_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* hw/rtl/akgd_front.sv */
module akgd_front (
	input  logic            clk,
	input  logic            arst_n,
	akgd_in_if.sink         in_item,
	akgd_cfg_if.sink        cfg,
	input  logic            q_full,
	output logic            push,
	output akgd_pkg::item_t push_item,
	output akgd_pkg::cfg_t  cfg_regs
);

	akgd_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_band_low      <= akgd_pkg::UP_BAND_LOW_RST;
			cfg_q.up_band_high     <= akgd_pkg::UP_BAND_HIGH_RST;
			cfg_q.enter_band_low   <= akgd_pkg::ENTER_BAND_LOW_RST;
			cfg_q.enter_band_high  <= akgd_pkg::ENTER_BAND_HIGH_RST;
			cfg_q.hold_time_ms     <= akgd_pkg::HOLD_TIME_RST;
			cfg_q.double_window_ms <= akgd_pkg::DOUBLE_WINDOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				akgd_pkg::REG_UP_BAND_LOW:
					cfg_q.up_band_low <= cfg.data[akgd_pkg::SAMPLE_W-1:0];
				akgd_pkg::REG_UP_BAND_HIGH:
					cfg_q.up_band_high <= cfg.data[akgd_pkg::SAMPLE_W-1:0];
				akgd_pkg::REG_ENTER_BAND_LOW:
					cfg_q.enter_band_low <= cfg.data[akgd_pkg::SAMPLE_W-1:0];
				akgd_pkg::REG_ENTER_BAND_HIGH:
					cfg_q.enter_band_high <= cfg.data[akgd_pkg::SAMPLE_W-1:0];
				akgd_pkg::REG_HOLD_TIME:
					cfg_q.hold_time_ms <= cfg.data[akgd_pkg::MS_W-1:0];
				akgd_pkg::REG_DOUBLE_WINDOW:
					cfg_q.double_window_ms <= cfg.data[akgd_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// band test: low inclusive, high exclusive, empty when low >= high
	assign in_item.ready      = !q_full;
	assign push               = in_item.valid && !q_full;
	assign push_item.is_up    = (in_item.sample >= cfg_q.up_band_low)
		&& (in_item.sample < cfg_q.up_band_high);
	assign push_item.is_enter = (in_item.sample >= cfg_q.enter_band_low)
		&& (in_item.sample < cfg_q.enter_band_high);
	assign push_item.now_ms   = in_item.now_ms;

endmodule

/* hw/rtl/akgd_queue.sv */
module akgd_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  akgd_pkg::item_t          push_item,
	input  logic                     pop,
	output akgd_pkg::item_t          pop_item,
	output akgd_pkg::queue_status_t  status
);

	localparam int                           DEPTH = akgd_pkg::QUEUE_DEPTH;
	localparam logic [akgd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		akgd_pkg::QUEUE_PTR_W'(DEPTH - 1);
	localparam logic [akgd_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
		akgd_pkg::QUEUE_CNT_W'(DEPTH);

	akgd_pkg::item_t                     entry_q [DEPTH];
	logic [akgd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [akgd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [akgd_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign pop_item     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/akgd_back.sv */
module akgd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  akgd_pkg::cfg_t          cfg_regs,
	input  akgd_pkg::queue_status_t q_status,
	input  akgd_pkg::item_t         item,
	output logic                    pop,
	akgd_out_if.source              out_event
);

	logic                        up_holding_q;
	logic [akgd_pkg::TIME_W-1:0] hold_start_q;
	logic                        mute_fired_q;
	logic                        enter_down_q;
	logic [akgd_pkg::TIME_W-1:0] last_enter_edge_q;
	logic                        out_valid_q;
	akgd_pkg::event_kind_t       out_kind_q;

	logic [akgd_pkg::TIME_W-1:0] hold_elapsed;
	logic [akgd_pkg::TIME_W-1:0] enter_gap;
	logic                        mute_ev;
	logic                        enter_edge;
	logic                        home_ev;

	// wrapping differences
	assign hold_elapsed = item.now_ms - hold_start_q;
	assign enter_gap    = item.now_ms - last_enter_edge_q;

	assign mute_ev    = item.is_up && up_holding_q && !mute_fired_q
		&& (hold_elapsed >= akgd_pkg::TIME_W'(cfg_regs.hold_time_ms));
	assign enter_edge = item.is_enter && !enter_down_q;
	// zero stored edge means nothing pending
	assign home_ev    = enter_edge && (last_enter_edge_q != '0)
		&& (enter_gap <= akgd_pkg::TIME_W'(cfg_regs.double_window_ms));

	assign pop = !q_status.empty && (!out_valid_q || out_event.ready);

	assign out_event.valid      = out_valid_q;
	assign out_event.event_kind = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_holding_q      <= 1'b0;
			hold_start_q      <= '0;
			mute_fired_q      <= 1'b0;
			enter_down_q      <= 1'b0;
			last_enter_edge_q <= '0;
		end else if (pop) begin
			if (item.is_up) begin
				if (!up_holding_q) begin
					up_holding_q <= 1'b1;
					hold_start_q <= item.now_ms;
					mute_fired_q <= 1'b0;
				end else if (mute_ev) begin
					mute_fired_q <= 1'b1;
				end
			end else begin
				up_holding_q <= 1'b0;
				mute_fired_q <= 1'b0;
			end
			if (enter_edge) begin
				last_enter_edge_q <= home_ev ? '0 : item.now_ms;
			end
			enter_down_q <= item.is_enter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (mute_ev || home_ev)) begin
			out_valid_q <= 1'b1;
		end else if (out_event.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// mute wins when both fire in one beat
	always_ff @(posedge clk) begin
		if (pop && (mute_ev || home_ev)) begin
			out_kind_q <= mute_ev ? akgd_pkg::EVENT_MUTE : akgd_pkg::EVENT_HOME;
		end
	end

endmodule

/* hw/rtl/adc_keypad_gesture_detector.sv */
// keypad gesture detector: long press on UP gives mute, double press on ENTER gives home
//
// in_item   : one beat per converter sample, carrying sample and the millisecond
//             timestamp now_ms; one beat can be taken every clock cycle while the queue is not full
// out_event : one beat per sample that fires a gesture (mute wins a tie), event_kind
//             0 mute, 1 home; most samples give no beat at all
// cfg       : register writes, index 0..5 = up low/high, enter low/high, hold
//             time, double window; always ready, unknown indexes are dropped
//
// a taken sample is classified against the bands and written into a two-entry
// queue; the gesture logic pops it from there and, if it fires, the event is
// registered in the output register at that pop
// throughput is one sample per cycle while out_event does not stall; the
// gesture logic updates its state on every pop
// when out_event stalls the gesture logic stops popping, the two-entry queue fills
// and in_item.ready then drops until the event is taken
// reset loads the default thresholds, clears the hold/press state and the
// queue; no clearing pass is needed, the block is ready right after reset
module adc_keypad_gesture_detector (
	input  logic       clk,
	input  logic       arst_n,
	akgd_in_if.sink    in_item,
	akgd_out_if.source out_event,
	akgd_cfg_if.sink   cfg
);

	akgd_pkg::cfg_t          cfg_regs;
	akgd_pkg::item_t         push_item;
	akgd_pkg::item_t         pop_item;
	akgd_pkg::queue_status_t q_status;
	logic                    push;
	logic                    pop;

	// front: config registers and band classification
	akgd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg       (cfg),
		.q_full    (q_status.full),
		.push      (push),
		.push_item (push_item),
		.cfg_regs  (cfg_regs)
	);

	// decoupling queue, lets either side stall on its own
	akgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	// back: hold timer, press pairing and output register
	akgd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_regs),
		.q_status  (q_status),
		.item      (pop_item),
		.pop       (pop),
		.out_event (out_event)
	);

`ifndef SYNTHESIS
	// queue can never be both full and empty
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty together");

	// nothing is popped from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// a stalled event blocks the gesture logic
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_event.valid && !out_event.ready) |-> !pop)
		else $error("queue popped while output stalled");
`endif

endmodule

/* sim/tb_adc_keypad_gesture_detector.sv */
module tb_adc_keypad_gesture_detector;
	import akgd_pkg::*;

	// a taken sample beat passes the queue before its event is registered at the output
	localparam int SETTLE_CYCLES = 4;
	// far beyond the slowest legal run
	localparam int RUN_LIMIT     = 3_000_000;
	localparam int REPORT_LIMIT  = 20;

	// register indexes outside the list, writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

	logic clk;
	logic arst_n;

	akgd_in_if  in_item_if();
	akgd_out_if out_event_if();
	akgd_cfg_if cfg_if();

	adc_keypad_gesture_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item_if),
		.out_event (out_event_if),
		.cfg       (cfg_if)
	);

	// gesture tracker state, mirrors the block
	cfg_t              thresholds;
	logic              up_held;
	logic [TIME_W-1:0] hold_origin;
	logic              mute_sent;
	logic              enter_pressed;
	logic [TIME_W-1:0] enter_edge_ms;

	// events still owed by the block, oldest first
	event_kind_t expected_events[$];

	// idling controls for the sender and the receiver
	bit receiver_idles;
	bit sender_idles;
	int receiver_holdoff;

	logic [TIME_W-1:0] ms_clock;

	int fault_count;
	int samples_sent;
	int events_seen;
	int mutes_due;
	int homes_due;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb_adc_keypad_gesture_detector NOT OK");
		$finish;
	end

	function automatic bit in_band(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] lo,
			input logic [SAMPLE_W-1:0] hi);
		return (v >= lo) && (v < hi);
	endfunction

	function automatic void reset_tracker();
		thresholds.up_band_low      = UP_BAND_LOW_RST;
		thresholds.up_band_high     = UP_BAND_HIGH_RST;
		thresholds.enter_band_low   = ENTER_BAND_LOW_RST;
		thresholds.enter_band_high  = ENTER_BAND_HIGH_RST;
		thresholds.hold_time_ms     = HOLD_TIME_RST;
		thresholds.double_window_ms = DOUBLE_WINDOW_RST;
		up_held       = 1'b0;
		hold_origin   = '0;
		mute_sent     = 1'b0;
		enter_pressed = 1'b0;
		enter_edge_ms = '0;
	endfunction

	// one step of the gesture rules for a sample that the block has taken
	function automatic void predict_gesture(input logic [SAMPLE_W-1:0] s,
			input logic [TIME_W-1:0] t);
		logic              is_up;
		logic              is_enter;
		logic              mute_now;
		logic              home_now;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] gap;
		is_up    = in_band(s, thresholds.up_band_low, thresholds.up_band_high);
		is_enter = in_band(s, thresholds.enter_band_low, thresholds.enter_band_high);
		mute_now = 1'b0;
		home_now = 1'b0;
		elapsed  = t - hold_origin;
		gap      = t - enter_edge_ms;

		if (is_up) begin
			if (!up_held) begin
				// first UP sample only opens the hold
				up_held     = 1'b1;
				hold_origin = t;
				mute_sent   = 1'b0;
			end else if (!mute_sent && elapsed >= {16'b0, thresholds.hold_time_ms}) begin
				mute_sent = 1'b1;
				mute_now  = 1'b1;
			end
		end else begin
			up_held   = 1'b0;
			mute_sent = 1'b0;
		end

		// a stored edge time of zero means nothing pending
		if (is_enter && !enter_pressed) begin
			if (enter_edge_ms != '0 && gap <= {16'b0, thresholds.double_window_ms}) begin
				home_now      = 1'b1;
				enter_edge_ms = '0;
			end else begin
				enter_edge_ms = t;
			end
		end
		enter_pressed = is_enter;

		// mute wins when both fire, the home edges are consumed all the same
		if (mute_now) begin
			expected_events.push_back(EVENT_MUTE);
			mutes_due++;
		end else if (home_now) begin
			expected_events.push_back(EVENT_HOME);
			homes_due++;
		end
	endfunction

	// one sample beat, with the sender's own random gap in front when the sender idles
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
		int gap;
		gap = sender_idles ? $urandom_range(4, 0) : 0;
		if (gap > 0) begin
			in_item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item_if.valid  <= 1'b1;
		in_item_if.sample <= s;
		in_item_if.now_ms <= t;
		do @(posedge clk); while (!in_item_if.ready);
		predict_gesture(s, t);
		samples_sent++;
	endtask

	// stop offering samples and let the block run dry
	task automatic wait_idle();
		in_item_if.valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		// samples that raise nothing may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves valid high so that back-to-back writes need no gap
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_UP_BAND_LOW:     thresholds.up_band_low      = value[SAMPLE_W-1:0];
			REG_UP_BAND_HIGH:    thresholds.up_band_high     = value[SAMPLE_W-1:0];
			REG_ENTER_BAND_LOW:  thresholds.enter_band_low   = value[SAMPLE_W-1:0];
			REG_ENTER_BAND_HIGH: thresholds.enter_band_high  = value[SAMPLE_W-1:0];
			REG_HOLD_TIME:       thresholds.hold_time_ms     = value;
			REG_DOUBLE_WINDOW:   thresholds.double_window_ms = value;
			default: ;
		endcase
	endtask

	// junk in the unused top bits of a band register
	function automatic logic [CFG_DATA_W-1:0] pad_band(input logic [SAMPLE_W-1:0] v);
		logic [CFG_DATA_W-SAMPLE_W-1:0] junk;
		junk = (CFG_DATA_W-SAMPLE_W)'($urandom_range(15, 0));
		return {junk, v};
	endfunction

	// called only once the block is idle
	task automatic configure(input cfg_t setting);
		write_register(REG_UP_BAND_LOW,     pad_band(setting.up_band_low));
		write_register(REG_UP_BAND_HIGH,    pad_band(setting.up_band_high));
		write_register(REG_ENTER_BAND_LOW,  pad_band(setting.enter_band_low));
		write_register(REG_ENTER_BAND_HIGH, pad_band(setting.enter_band_high));
		write_register(REG_HOLD_TIME,       setting.hold_time_ms);
		write_register(REG_DOUBLE_WINDOW,   setting.double_window_ms);
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	function automatic cfg_t make_setting(input int up_lo, input int up_hi, input int en_lo,
			input int en_hi, input int hold, input int window);
		cfg_t s;
		s.up_band_low      = SAMPLE_W'(up_lo);
		s.up_band_high     = SAMPLE_W'(up_hi);
		s.enter_band_low   = SAMPLE_W'(en_lo);
		s.enter_band_high  = SAMPLE_W'(en_hi);
		s.hold_time_ms     = MS_W'(hold);
		s.double_window_ms = MS_W'(window);
		return s;
	endfunction

	// mostly sane bands, now and then one wraps round and ends up empty
	function automatic cfg_t random_setting();
		int up_lo;
		int en_lo;
		up_lo = $urandom_range(1500, 0);
		en_lo = $urandom_range(3600, 1000);
		return make_setting(up_lo, up_lo + $urandom_range(900, 1), en_lo,
			en_lo + $urandom_range(700, 1), $urandom_range(300, 0), $urandom_range(300, 0));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_in(input logic [SAMPLE_W-1:0] lo,
			input logic [SAMPLE_W-1:0] hi);
		if (lo < hi)
			return SAMPLE_W'($urandom_range(hi - 1, lo));
		return SAMPLE_W'($urandom_range(4095, 0));
	endfunction

	// a reading in neither band, if one can be found quickly
	function automatic logic [SAMPLE_W-1:0] pick_quiet();
		logic [SAMPLE_W-1:0] s;
		s = '0;
		for (int k = 0; k < 8; k++) begin
			s = SAMPLE_W'($urandom_range(4095, 0));
			if (!in_band(s, thresholds.up_band_low, thresholds.up_band_high) &&
					!in_band(s, thresholds.enter_band_low, thresholds.enter_band_high))
				return s;
		end
		return s;
	endfunction

	// checker: every event beat against the oldest one owed
	initial begin
		event_kind_t want;
		out_event_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			if (receiver_holdoff > 0) begin
				stall = receiver_holdoff;
				receiver_holdoff = 0;
			end else begin
				stall = receiver_idles ? $urandom_range(4, 0) : 0;
			end
			if (stall > 0) begin
				out_event_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_event_if.ready <= 1'b1;
			do @(posedge clk); while (!out_event_if.valid);
			events_seen++;
			if (expected_events.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: event_kind %b with nothing expected", $time,
						out_event_if.event_kind);
			end else begin
				want = expected_events.pop_front();
				if (out_event_if.event_kind !== want) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("%0t: event_kind expected %b got %b", $time, want,
							out_event_if.event_kind);
				end
			end
		end
	end

	// thresholds straight after reset, band edges and reading extremes
	task automatic test_reset_thresholds();
		send_sample(12'd300, 32'd100);     // lowest UP reading opens the hold
		send_sample(12'd799, 32'd3000);    // top of UP band, hold not yet met
		send_sample(12'd500, 32'd5100);    // exactly the hold time, mute
		send_sample(12'd4095, 32'd5200);   // full scale, no band, hold released
		send_sample(12'd1600, 32'd6000);   // first ENTER edge
		send_sample(12'd0, 32'd6100);
		send_sample(12'd2999, 32'd6500);   // a further ENTER edge at the window limit, home
		send_sample(12'd800, 32'd6600);    // exclusive bound, not UP
		wait_idle();
	endtask

	task automatic test_special_cases();
		// an edge stored at time zero cannot be paired
		send_sample(12'd2000, 32'd0);
		send_sample(12'd0, 32'd10);
		send_sample(12'd2000, 32'd100);
		send_sample(12'd0, 32'd150);
		send_sample(12'd2000, 32'd200);
		wait_idle();

		// ENTER band inside the UP band, mute and home due on the same sample
		configure(make_setting(100, 4000, 1000, 2000, 15, 100));
		send_sample(12'd500, 32'd10);
		send_sample(12'd1500, 32'd12);
		send_sample(12'd500, 32'd14);
		send_sample(12'd1500, 32'd30);     // only mute comes out
		send_sample(12'd500, 32'd32);
		send_sample(12'd1500, 32'd40);     // edges were used up, no home
		wait_idle();

		// zero hold and zero window
		configure(make_setting(300, 800, 1600, 3000, 0, 0));
		send_sample(12'd500, 32'd7);
		send_sample(12'd500, 32'd7);       // second UP sample fires at once
		send_sample(12'd2000, 32'd9);
		send_sample(12'd0, 32'd9);
		send_sample(12'd2000, 32'd9);      // same millisecond, home
		wait_idle();

		// hold of 512 and the widest window, the hold difference across the 32-bit wrap
		configure(make_setting(300, 800, 1600, 3000, 512, 65535));
		send_sample(12'd500, 32'hFFFF_FF00);
		send_sample(12'd500, 32'h0000_0100);
		send_sample(12'd2000, 32'hFFFF_0000);
		send_sample(12'd0, 32'hFFFF_8000);
		send_sample(12'd2000, 32'hFFFF_FFFF);
		wait_idle();

		// spare indexes are dropped, then both bands empty
		write_register(REG_SPARE_LOW, 16'hFFFF);
		write_register(REG_SPARE_HIGH, 16'h0000);
		configure(make_setting(800, 800, 3000, 1600, 65535, 0));
		send_sample(12'd800, 32'd50);
		send_sample(12'd2000, 32'd60);
		wait_idle();
	endtask

	// receiver stops for a long stretch while samples keep coming
	task automatic test_output_stall();
		configure(make_setting(300, 800, 1600, 3000, 0, 500));
		sender_idles     = 1'b0;
		receiver_holdoff = 60;
		ms_clock         = 32'd1000;
		for (int k = 0; k < 14; k++) begin
			// two UP samples then a release, one mute per three beats
			send_sample(12'd400, ms_clock);
			send_sample(12'd600, ms_clock + 1);
			send_sample(12'd0, ms_clock + 2);
			ms_clock += 10;
		end
		wait_idle();
		sender_idles = 1'b1;
	endtask

	// well-formed holds and double presses with random content, plus noise
	task automatic run_gesture_mix(input int count);
		int                target;
		int                kind;
		logic [TIME_W-1:0] step;
		target = samples_sent + count;
		while (samples_sent < target) begin
			kind = $urandom_range(9, 0);
			if (kind < 4) begin
				step = $urandom_range(thresholds.hold_time_ms / 2 + 2, 0);
				repeat ($urandom_range(6, 2)) begin
					send_sample(pick_in(thresholds.up_band_low, thresholds.up_band_high),
						ms_clock);
					ms_clock += step;
				end
				if ($urandom_range(3, 0) != 0)
					send_sample(pick_quiet(), ms_clock);
			end else if (kind < 7) begin
				send_sample(pick_in(thresholds.enter_band_low, thresholds.enter_band_high),
					ms_clock);
				ms_clock += $urandom_range(20, 1);
				send_sample(pick_quiet(), ms_clock);
				// gap lands either side of the window
				ms_clock += $urandom_range(thresholds.double_window_ms +
					thresholds.double_window_ms / 4 + 2, 0);
				send_sample(pick_in(thresholds.enter_band_low, thresholds.enter_band_high),
					ms_clock);
				ms_clock += $urandom_range(20, 1);
				if ($urandom_range(1, 0) != 0)
					send_sample(pick_quiet(), ms_clock);
			end else if ($urandom_range(1, 0) != 0) begin
				send_sample(SAMPLE_W'($urandom_range(4095, 0)), $urandom());
			end else begin
				send_sample(SAMPLE_W'($urandom_range(4095, 0)), ms_clock);
				ms_clock += $urandom_range(1000, 0);
			end
			// now and then the sender waits for the block to empty
			if ($urandom_range(40, 0) == 0)
				wait_idle();
		end
		wait_idle();
	endtask

	task automatic test_random_settings();
		cfg_t setting;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: setting = make_setting(0, 4095, 0, 4095, 65535, 65535);
				3: setting = make_setting(4095, 0, 4095, 4095, 0, 0);
				default: setting = random_setting();
			endcase
			configure(setting);
			receiver_idles = (phase != 2) && ($urandom_range(3, 0) != 0);
			sender_idles   = (phase != 2) && ($urandom_range(3, 0) != 0);
			ms_clock = (phase == 4) ? 32'hFFFF_F000 : $urandom_range(100000, 1);
			run_gesture_mix((phase == 3) ? 60 : 140);
		end
		receiver_idles = 1'b1;
		sender_idles   = 1'b1;
	endtask

	initial begin
		arst_n            <= 1'b0;
		in_item_if.valid  <= 1'b0;
		in_item_if.sample <= '0;
		in_item_if.now_ms <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= '0;
		cfg_if.data       <= '0;
		receiver_idles   = 1'b1;
		sender_idles     = 1'b1;
		receiver_holdoff = 0;
		ms_clock         = '0;
		fault_count      = 0;
		samples_sent     = 0;
		events_seen      = 0;
		mutes_due        = 0;
		homes_due        = 0;
		settings_used    = 0;
		reset_tracker();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_thresholds();
		test_special_cases();
		test_output_stall();
		test_random_settings();
		wait_idle();

		$display("covered %0d samples over %0d threshold settings", samples_sent,
			settings_used);
		$display("%0d events checked: %0d mute, %0d home", events_seen, mutes_due, homes_due);
		if (fault_count == 0)
			$display("tb_adc_keypad_gesture_detector OK");
		else
			$display("tb_adc_keypad_gesture_detector NOT OK");
		$finish;
	end

endmodule
